>>> rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and helpers for the pressure/temperature
// compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int ADC_BITS   = 20;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [19:0] ADC_MASK = 20'(((1 << ADC_BITS) - 1) << (20 - ADC_BITS));

  // 2^35 / 10 rounded up, exact quotient for any 32-bit dividend
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  localparam logic signed [63:0] PRESS_MAX = 64'sd262143;

  // configuration register indexes
  localparam logic [1:0] REG_TEMP_CAL  = 2'd0;
  localparam logic [1:0] REG_PRES_LOW  = 2'd1;
  localparam logic [1:0] REG_PRES_MID  = 2'd2;
  localparam logic [1:0] REG_PRES_HIGH = 2'd3;

  typedef struct packed {
    logic [47:0] temp_cal;
    logic [47:0] pres_cal_low;
    logic [47:0] pres_cal_mid;
    logic [47:0] pres_cal_high;
  } ptc_cal_t;

  // job handed from the temperature front end to the pressure back end
  typedef struct packed {
    logic signed [31:0] tf;
    logic [19:0]        adc_p;
    logic signed [15:0] tenths;
  } ptc_job_t;

  typedef struct packed {
    logic signed [15:0] temp_tenths;
    logic [17:0]        press_pa;
    logic               press_valid;
  } ptc_result_t;

  function automatic logic signed [31:0] sx16_32(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic signed [63:0] sx16_64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

>>> rtl/ptc_in_if.sv
// ----------------------------------------------------------------------------
// ptc_in_if
// Raw reading channel: one temperature and one pressure sample per request.
// ----------------------------------------------------------------------------
interface ptc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temp;
  logic [19:0] raw_press;

  modport source (output valid, raw_temp, raw_press, input ready);
  modport sink   (input valid, raw_temp, raw_press, output ready);
endinterface

>>> rtl/ptc_out_if.sv
// ----------------------------------------------------------------------------
// ptc_out_if
// Result channel: compensated temperature and pressure per request.
// ----------------------------------------------------------------------------
interface ptc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temp_tenths;
  logic [17:0]        press_pa;
  logic               press_valid;

  modport source (output valid, temp_tenths, press_pa, press_valid, input ready);
  modport sink   (input valid, temp_tenths, press_pa, press_valid, output ready);
endinterface

>>> rtl/ptc_cfg_if.sv
// ----------------------------------------------------------------------------
// ptc_cfg_if
// Calibration register write channel.
// ----------------------------------------------------------------------------
interface ptc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/ptc_front.sv
// ----------------------------------------------------------------------------
// ptc_front
// Four-stage temperature pipeline: accepts raw readings, computes the fine
// temperature and the tenths result, and hands jobs to the queue.
// ----------------------------------------------------------------------------
module ptc_front import ptc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ptc_cal_t cal,
  ptc_in_if.sink   sample,
  output ptc_job_t job,
  output logic     job_valid,
  input  logic     job_ready
);

  logic [15:0]        t1;
  logic signed [31:0] t2, t3;
  logic [19:0]        adc_t;
  logic [31:0]        a_c, b_c;
  logic               adv;

  logic               v1, v2, v3, v4;
  logic [31:0]        s1_pa, s1_pbb;
  logic [19:0]        s1_adc_p, s2_adc_p, s3_adc_p, s4_adc_p;
  logic signed [31:0] s2_v1, s2_pv2;
  logic signed [31:0] s3_tf, s4_tf;
  logic               s3_neg, s4_neg;
  logic [31:0]        s3_mag;
  logic [63:0]        s4_prod;

  logic signed [31:0] sh12, tf_c, t5_c, th_c;
  logic [28:0]        q_c;

  assign t1    = cal.temp_cal[15:0];
  assign t2    = sx16_32(cal.temp_cal[31:16]);
  assign t3    = sx16_32(cal.temp_cal[47:32]);
  assign adc_t = sample.raw_temp & ADC_MASK;
  assign a_c   = {15'b0, adc_t[19:3]} - {15'b0, t1, 1'b0};
  assign b_c   = {16'b0, adc_t[19:4]} - {16'b0, t1};

  // whole pipe moves together; stalls only when the last stage cannot push
  assign adv          = !v4 || job_ready;
  assign sample.ready = adv;

  assign sh12 = $signed(s1_pbb) >>> 12;
  assign tf_c = s2_v1 + (s2_pv2 >>> 14);
  assign t5_c = tf_c * 32'sd5 + 32'sd128;
  assign th_c = t5_c >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= sample.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pa    <= a_c * t2;
      s1_pbb   <= b_c * b_c;
      s1_adc_p <= sample.raw_press & ADC_MASK;

      s2_v1    <= $signed(s1_pa) >>> 11;
      s2_pv2   <= sh12 * t3;
      s2_adc_p <= s1_adc_p;

      s3_tf    <= tf_c;
      s3_neg   <= th_c[31];
      s3_mag   <= th_c[31] ? 32'(-th_c) : th_c;
      s3_adc_p <= s2_adc_p;

      s4_prod  <= s3_mag * RECIP10;
      s4_tf    <= s3_tf;
      s4_neg   <= s3_neg;
      s4_adc_p <= s3_adc_p;
    end
  end

  // divide by ten truncates toward zero: work on the magnitude
  assign q_c = s4_prod[63:35];

  always_comb begin
    job.tf    = s4_tf;
    job.adc_p = s4_adc_p;
    if (!s4_neg) begin
      job.tenths = (q_c > 29'd32767) ? 16'sh7FFF : q_c[15:0];
    end else begin
      job.tenths = (q_c > 29'd32768) ? 16'sh8000 : 16'(16'd0 - q_c[15:0]);
    end
  end

  assign job_valid = v4;

endmodule

>>> rtl/ptc_fifo.sv
// ----------------------------------------------------------------------------
// ptc_fifo
// Short job queue between the temperature front end and the pressure unit.
// ----------------------------------------------------------------------------
module ptc_fifo import ptc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ptc_job_t wr_job,
  input  logic     wr_valid,
  output logic     wr_ready,
  output ptc_job_t rd_job,
  output logic     rd_valid,
  input  logic     rd_pop
);

  ptc_job_t             slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_AW:0]     count;
  logic                 push, pop;

  assign wr_ready = (count != (FIFO_AW+1)'(FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;
  assign rd_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_job;
  end

endmodule

>>> rtl/ptc_mul.sv
// ----------------------------------------------------------------------------
// ptc_mul
// 64 x 64 -> 64 wrapping multiply from three 32 x 32 partial products,
// one per cycle on a single multiplier.
// ----------------------------------------------------------------------------
module ptc_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic [63:0] a_r, b_r, pp, acc;
  logic [31:0] opx, opy;
  logic [1:0]  cnt;
  logic        busy;

  always_comb begin
    case (cnt)
      2'd0:    begin opx = a_r[31:0];  opy = b_r[31:0];  end
      2'd1:    begin opx = a_r[31:0];  opy = b_r[63:32]; end
      default: begin opx = a_r[63:32]; opy = b_r[31:0];  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (busy) begin
      pp <= opx * opy;
      case (cnt)
        2'd1:    acc <= pp;
        2'd2,
        2'd3:    acc <= acc + {pp[31:0], 32'b0};
        default: acc <= acc;
      endcase
    end
  end

  assign prod = acc;

endmodule

>>> rtl/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// 64-bit signed divide, truncating, restoring radix-2 (one bit per cycle).
// ----------------------------------------------------------------------------
module ptc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] ud, rem, qr;
  logic [64:0] rem_sh, diff;
  logic [5:0]  cnt;
  logic        busy, fin, neg;

  assign rem_sh = {rem, qr[63]};
  assign diff   = rem_sh - {1'b0, ud};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd63) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ud  <= den[63] ? 64'(-den) : den;
      qr  <= num[63] ? 64'(-num) : num;
      neg <= num[63] ^ den[63];
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (!diff[64]) begin
        rem <= diff[63:0];
        qr  <= {qr[62:0], 1'b1};
      end else begin
        rem <= rem_sh[63:0];
        qr  <= {qr[62:0], 1'b0};
      end
    end
    if (fin) quo <= neg ? 64'(-qr) : qr;
  end

endmodule

>>> rtl/ptc_back.sv
// ----------------------------------------------------------------------------
// ptc_back
// Pressure sequencer: steps each job through the 64-bit compensation on a
// shared multiplier and divider, then holds the result for the receiver.
// ----------------------------------------------------------------------------
module ptc_back import ptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ptc_cal_t    cal,
  input  ptc_job_t    job,
  input  logic        job_valid,
  output logic        job_pop,
  output ptc_result_t res,
  output logic        res_valid,
  input  logic        res_ready
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M1   = 4'd1;
  localparam logic [3:0] ST_M2   = 4'd2;
  localparam logic [3:0] ST_M3   = 4'd3;
  localparam logic [3:0] ST_M4   = 4'd4;
  localparam logic [3:0] ST_M5   = 4'd5;
  localparam logic [3:0] ST_M6   = 4'd6;
  localparam logic [3:0] ST_CHK  = 4'd7;
  localparam logic [3:0] ST_M7   = 4'd8;
  localparam logic [3:0] ST_DIV  = 4'd9;
  localparam logic [3:0] ST_M8   = 4'd10;
  localparam logic [3:0] ST_M9   = 4'd11;
  localparam logic [3:0] ST_M10  = 4'd12;
  localparam logic [3:0] ST_SUM  = 4'd13;
  localparam logic [3:0] ST_SAT  = 4'd14;
  localparam logic [3:0] ST_DONE = 4'd15;

  logic [3:0]         state;
  logic               pend;
  logic signed [63:0] w1, m1, w2, pn, ps, x1;
  logic [19:0]        adc_p;
  logic signed [15:0] tenths;
  logic [17:0]        press;
  logic               pvalid;

  logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0]        mul_a, mul_b, mul_prod, div_quo;
  logic signed [63:0] r, q_c, sat_q;
  logic               is_mul, mul_start, mul_done, div_start, div_done;

  assign p1 = {48'b0, cal.pres_cal_low[15:0]};
  assign p2 = sx16_64(cal.pres_cal_low[31:16]);
  assign p3 = sx16_64(cal.pres_cal_low[47:32]);
  assign p4 = sx16_64(cal.pres_cal_mid[15:0]);
  assign p5 = sx16_64(cal.pres_cal_mid[31:16]);
  assign p6 = sx16_64(cal.pres_cal_mid[47:32]);
  assign p7 = sx16_64(cal.pres_cal_high[15:0]);
  assign p8 = sx16_64(cal.pres_cal_high[31:16]);
  assign p9 = sx16_64(cal.pres_cal_high[47:32]);

  always_comb begin
    is_mul = 1'b1;
    case (state)
      ST_M1:   begin mul_a = w1; mul_b = w1; end
      ST_M2:   begin mul_a = m1; mul_b = p6; end
      ST_M3:   begin mul_a = w1; mul_b = p5; end
      ST_M4:   begin mul_a = m1; mul_b = p3; end
      ST_M5:   begin mul_a = w1; mul_b = p2; end
      ST_M6:   begin mul_a = w1; mul_b = p1; end
      ST_M7:   begin mul_a = pn; mul_b = 64'd3125; end
      ST_M8:   begin mul_a = p9; mul_b = ps; end
      ST_M9:   begin mul_a = x1; mul_b = ps; end
      ST_M10:  begin mul_a = p8; mul_b = pn; end
      default: begin mul_a = '0; mul_b = '0; is_mul = 1'b0; end
    endcase
  end

  assign mul_start = is_mul && !pend;
  assign div_start = (state == ST_DIV) && !pend;
  assign job_pop   = (state == ST_IDLE) && job_valid;
  assign r         = $signed(mul_prod);
  assign q_c       = pn >>> 8;

  always_comb begin
    if (q_c[63])             sat_q = '0;
    else if (q_c > PRESS_MAX) sat_q = PRESS_MAX;
    else                      sat_q = q_c;
  end

  ptc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ptc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (pn),
    .den   (w1),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // in ST_DONE the output register is reloaded below
      if (res_valid && res_ready && state != ST_DONE) res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            w1     <= {{32{job.tf[31]}}, job.tf} - 64'sd128000;
            adc_p  <= job.adc_p;
            tenths <= job.tenths;
            state  <= ST_M1;
          end
        end
        ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9, ST_M10: begin
          if (!pend) begin
            pend <= 1'b1;
          end else if (mul_done) begin
            pend <= 1'b0;
            case (state)
              ST_M1:   begin m1 <= r; state <= ST_M2; end
              ST_M2:   begin w2 <= r; state <= ST_M3; end
              ST_M3:   begin w2 <= w2 + (r <<< 17) + (p4 <<< 35); state <= ST_M4; end
              ST_M4:   begin m1 <= r >>> 8; state <= ST_M5; end
              // the 2^47 offset folds in here
              ST_M5:   begin
                w1    <= m1 + (r <<< 12) + 64'sh0000_8000_0000_0000;
                state <= ST_M6;
              end
              ST_M6:   begin w1 <= r >>> 33; state <= ST_CHK; end
              ST_M7:   begin pn <= r; state <= ST_DIV; end
              ST_M8:   begin x1 <= r; state <= ST_M9; end
              ST_M9:   begin x1 <= r >>> 25; state <= ST_M10; end
              default: begin m1 <= r >>> 19; state <= ST_SUM; end
            endcase
          end
        end
        ST_CHK: begin
          if (w1 == '0) begin
            press  <= '0;
            pvalid <= 1'b0;
            state  <= ST_DONE;
          end else begin
            pn    <= ((64'd1048576 - {44'b0, adc_p}) << 31) - w2;
            state <= ST_M7;
          end
        end
        ST_DIV: begin
          if (!pend) begin
            pend <= 1'b1;
          end else if (div_done) begin
            pend  <= 1'b0;
            pn    <= $signed(div_quo);
            ps    <= $signed(div_quo) >>> 13;
            state <= ST_M8;
          end
        end
        ST_SUM: begin
          pn    <= ((pn + x1 + m1) >>> 8) + (p7 <<< 4);
          state <= ST_SAT;
        end
        ST_SAT: begin
          press  <= sat_q[17:0];
          pvalid <= 1'b1;
          state  <= ST_DONE;
        end
        ST_DONE: begin
          if (!res_valid || res_ready) begin
            res.temp_tenths <= tenths;
            res.press_pa    <= press;
            res.press_valid <= pvalid;
            res_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Barometric sensor compensation: raw temperature/pressure in, tenths of a
// degree C and pascals out, from four packed calibration registers.
// ----------------------------------------------------------------------------
// Usage:
//   sample : valid/ready request carrying raw_temp and raw_press (20 bits).
//   result : valid/ready request carrying temp_tenths, press_pa, press_valid;
//            exactly one result per sample, in order.
//   cfg    : valid/ready write of calibration register index 0..3; always
//            ready. Write only while no sample is in flight.
// Path: each sample passes through the temperature pipeline, then the queue,
//   then the pressure unit, which skips the last four products and the divide
//   when the pressure divisor is zero.
// Pressure unit: works on one job at a time and takes the next only after the
//   result register is loaded, stepping through ten 64-bit products on one
//   32x32 multiplier and a one-bit-per-cycle 64-bit divider. Up to 4 jobs
//   queue between the temperature pipeline and the pressure unit, so samples
//   keep being taken while it is busy.
// Reset: clears the calibration registers to zero and empties all stages.
// Stall: a held result keeps the pressure unit waiting; the queue fills and
//   then sample.ready drops. Nothing is dropped.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation import ptc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ptc_in_if.sink     sample,
  ptc_out_if.source  result,
  ptc_cfg_if.sink    cfg
);

  ptc_cal_t    cal;
  ptc_job_t    f_job, q_job;
  logic        f_valid, f_ready, q_valid, q_pop;
  ptc_result_t res;
  logic        res_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TEMP_CAL:  cal.temp_cal      <= cfg.data;
        REG_PRES_LOW:  cal.pres_cal_low  <= cfg.data;
        REG_PRES_MID:  cal.pres_cal_mid  <= cfg.data;
        REG_PRES_HIGH: cal.pres_cal_high <= cfg.data;
        default:       cal <= cal;
      endcase
    end
  end

  ptc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .sample    (sample),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (f_ready)
  );

  ptc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_job   (f_job),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_job   (q_job),
    .rd_valid (q_valid),
    .rd_pop   (q_pop)
  );

  ptc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .job       (q_job),
    .job_valid (q_valid),
    .job_pop   (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (result.ready)
  );

  assign result.valid       = res_valid;
  assign result.temp_tenths = res.temp_tenths;
  assign result.press_pa    = res.press_pa;
  assign result.press_valid = res.press_valid;

endmodule
